[rtl/packed_depth_row_unpacker_unit_defines.svh]
// Assertion macros for the packed depth row unpacker.
`ifndef PACKED_DEPTH_ROW_UNPACKER_UNIT_DEFINES_SVH
`define PACKED_DEPTH_ROW_UNPACKER_UNIT_DEFINES_SVH

// Property that holds in the same cycle.
`define PDRU_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pdru assertion failed");

// Condition in one cycle implies a condition in the next cycle.
`define PDRU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pdru assertion failed");

`endif

[rtl/pdru_pkg.sv]
// Types and constants shared by the packed depth row unpacker modules.
package pdru_pkg;

  localparam int unsigned PosW  = 11;
  localparam int unsigned OffW  = 10;
  localparam int unsigned WordW = 18;

  localparam logic [7:0] PktSkipLo  = 8'd73;
  localparam logic [7:0] PktSkipHi  = 8'd146;
  localparam logic [7:0] PktBandC   = 8'd219;
  localparam logic [7:0] PktBaseC   = 8'd220;
  localparam logic [7:0] PktBaseB   = 8'd147;
  localparam logic [7:0] PktBaseA   = 8'd74;
  localparam logic [OffW-1:0] OffStep = 10'd12;
  localparam logic [OffW-1:0] OffAddB = 10'd4;
  localparam logic [OffW-1:0] OffAddA = 10'd8;
  localparam logic [PosW-1:0] PosMax  = 11'd2047;

  localparam int unsigned GroupBytes  = 22;
  localparam int unsigned SampleBytes = 11;
  localparam logic [11:0] Recip11     = 12'd2979;

  localparam logic [3:0] SubK0 = 4'd1;
  localparam logic [3:0] SubK1 = 4'd4;
  localparam logic [3:0] SubK2 = 4'd6;
  localparam logic [3:0] SubK3 = 4'd9;

  typedef struct packed {
    logic [PosW-1:0]  pos;
    logic [OffW-1:0]  off;
    logic [7:0]       row;
    logic             skip;
    logic [WordW-1:0] word;
  } cap_t;

endpackage

[rtl/pdru_capture.sv]
// Input register: byte position, held bytes, row and offset of each request.
module pdru_capture import pdru_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic       adv_i,
  input  logic [7:0] packet_number_i,
  input  logic [7:0] data_byte_i,
  input  logic       packet_start_i,
  output logic       valid_o,
  output cap_t       cap_o
);

  logic [PosW-1:0] pos_q, pos_d, pos_cur;
  logic [15:0]     held_q, held_d, held_cur;
  logic [23:0]     word;
  logic [7:0]      base;
  logic            valid_q, valid_d;
  cap_t            cap_q, cap_d;

  always_comb begin
    pos_cur  = packet_start_i ? '0 : pos_q;
    held_cur = packet_start_i ? '0 : held_q;
    word     = {held_cur, data_byte_i};
    pos_d    = (pos_cur < PosMax) ? pos_cur + PosW'(1) : PosMax;
    held_d   = word[15:0];
    valid_d  = take_i ? 1'b1 : (adv_i ? 1'b0 : valid_q);

    base = packet_number_i;
    cap_d.row = packet_number_i;
    cap_d.off = '0;
    if (packet_number_i > PktBandC) begin
      base      = packet_number_i - PktBaseC;
      cap_d.off = OffW'(base) * OffStep;
      cap_d.row = packet_number_i - 8'd2;
    end else if (packet_number_i > PktSkipHi) begin
      base      = packet_number_i - PktBaseB;
      cap_d.off = OffW'(base) * OffStep + OffAddB;
      cap_d.row = packet_number_i - 8'd2;
    end else if (packet_number_i > PktSkipLo) begin
      base      = packet_number_i - PktBaseA;
      cap_d.off = OffW'(base) * OffStep + OffAddA;
      cap_d.row = packet_number_i - 8'd1;
    end else begin
      cap_d.off = OffW'(base) * OffStep;
    end
    cap_d.pos  = pos_cur;
    cap_d.skip = (packet_number_i == PktSkipLo) || (packet_number_i == PktSkipHi) ||
                 (pos_cur == PosMax);
    cap_d.word = word[WordW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      held_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (take_i) begin
        pos_q  <= pos_d;
        held_q <= held_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      cap_q <= cap_d;
    end
  end

  assign valid_o = valid_q;
  assign cap_o   = cap_q;

endmodule

[rtl/pdru_decode.sv]
// Sample decode: place in the group, column, frame index and depth bits.
module pdru_decode import pdru_pkg::*; #(
  parameter int unsigned ROW_PIXELS     = 320,
  parameter int unsigned GROUPS_PER_ROW = 40
) (
  input  cap_t        cap_i,
  output logic        hit_o,
  output logic [16:0] pixel_index_o,
  output logic [10:0] depth_value_o
);

  localparam int unsigned Region = GROUPS_PER_ROW * GroupBytes;
  localparam int unsigned ProdW  = 8 + $clog2(ROW_PIXELS + 1);
  localparam int unsigned SumW   = (ProdW + 1 > 17) ? ProdW + 1 : 17;

  logic [PosW-1:0] r;
  logic [22:0]     prod;
  logic [7:0]      q;
  logic [PosW-1:0] q_x11;
  logic [3:0]      sub;
  logic [1:0]      k;
  logic            sub_hit;
  logic [9:0]      col;
  logic [SumW-1:0] sum;

  always_comb begin
    r     = cap_i.pos - PosW'(cap_i.off);
    prod  = 23'(r) * 23'(Recip11);
    q     = prod[22:15];
    q_x11 = PosW'(q) * PosW'(SampleBytes);
    sub   = 4'(r - q_x11);

    k             = 2'd0;
    sub_hit       = 1'b1;
    depth_value_o = cap_i.word[15:5];
    case (sub)
      SubK0: begin
        k             = 2'd0;
        depth_value_o = cap_i.word[15:5];
      end
      SubK1: begin
        k             = 2'd1;
        depth_value_o = cap_i.word[17:7];
      end
      SubK2: begin
        k             = 2'd2;
        depth_value_o = cap_i.word[11:1];
      end
      SubK3: begin
        k             = 2'd3;
        depth_value_o = cap_i.word[13:3];
      end
      default: begin
        sub_hit = 1'b0;
      end
    endcase

    col           = {q, k};
    sum           = SumW'(cap_i.row) * SumW'(ROW_PIXELS) + SumW'(col);
    pixel_index_o = sum[16:0];
    hit_o         = !cap_i.skip && (cap_i.pos >= PosW'(cap_i.off)) &&
                    (12'(r) < 12'(Region)) && sub_hit;
  end

endmodule

[rtl/packed_depth_row_unpacker_unit.sv]
// Top level of the packed depth row unpacker.
//
//  channel  dir  handshake               payload
//  s_axis   in   s_axis_tvalid/tready    tdata: packet_number, data_byte; tuser: packet_start
//  m_axis   out  m_axis_tvalid/tready    tdata: pixel_index, depth_value
//
// One byte per clock sustained while m_axis_tready does not stall a held result.
// Latency is set by the input register and the result register.
// Reset clears byte position, held bytes and both valid flags.
// A stalled result register holds; the input register refills in the same cycle
// the result register is freed.
`include "packed_depth_row_unpacker_unit_defines.svh"

module packed_depth_row_unpacker_unit import pdru_pkg::*; #(
  parameter int unsigned ROW_PIXELS     = 320,
  parameter int unsigned GROUPS_PER_ROW = 40
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // packet_number[7:0], data_byte[15:8]
  input  logic        s_axis_tuser,  // packet_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // pixel_index[16:0], depth_value[27:17], zero[31:28]
);

  logic        take, adv, cap_valid, hit;
  cap_t        cap;
  logic [16:0] pixel_index;
  logic [10:0] depth_value;
  logic        out_valid_q, out_valid_d;
  logic [16:0] pixel_index_q;
  logic [10:0] depth_value_q;

  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !cap_valid || adv;
  assign take          = s_axis_tvalid && s_axis_tready;

  pdru_capture u_capture (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .take_i          (take),
    .adv_i           (adv),
    .packet_number_i (s_axis_tdata[7:0]),
    .data_byte_i     (s_axis_tdata[15:8]),
    .packet_start_i  (s_axis_tuser),
    .valid_o         (cap_valid),
    .cap_o           (cap)
  );

  pdru_decode #(
    .ROW_PIXELS     (ROW_PIXELS),
    .GROUPS_PER_ROW (GROUPS_PER_ROW)
  ) u_decode (
    .cap_i         (cap),
    .hit_o         (hit),
    .pixel_index_o (pixel_index),
    .depth_value_o (depth_value)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (cap_valid && adv) begin
      out_valid_d = hit;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cap_valid && adv && hit) begin
      pixel_index_q <= pixel_index;
      depth_value_q <= depth_value;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, depth_value_q, pixel_index_q};

  `PDRU_ASSERT(a_ready_only_when_full, clk_i, rst_ni, !s_axis_tready |-> cap_valid)
  `PDRU_ASSERT_NEXT(a_miss_gives_nothing, clk_i, rst_ni, cap_valid && adv && !hit,
                    !m_axis_tvalid)
  `PDRU_ASSERT_NEXT(a_start_restarts, clk_i, rst_ni, take && s_axis_tuser,
                    cap.pos == '0)

endmodule
